// ----- hdl/scfd_pkg.sv -----
package scfd_pkg;

  // Largest total frame length accepted, counting every byte of the frame
  localparam int unsigned MAX_FRAME_BYTES = 256;
  // header, two length bytes, address, code, checksum, tail
  localparam int unsigned FIXED_BYTES     = 7;

  localparam int unsigned FLEN_W   = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned TOTAL_W  = 16;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_VALUE    = 2'd2;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd2000;
  localparam logic [7:0]        HEADER_RESET  = 8'h68;
  localparam logic [7:0]        TAIL_RESET    = 8'h16;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_BAD_LEN  = 3'd2,
    KIND_BAD_TAIL = 3'd3,
    KIND_BAD_SUM  = 3'd4,
    KIND_TIMEOUT  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [TICK_W-1:0] timeout_ticks;
    logic [7:0]        header_value;
    logic [7:0]        tail_value;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_address;
    logic [7:0] function_code;
    logic [7:0] payload_length;
  } result_t;

endpackage

// ----- hdl/sum_checked_frame_deframer.sv -----
// Channel   Direction  Handshake              Payload
// in        sink       in_valid_i/in_stall_o  func_i, rx_byte_i
// out       source     out_valid_o/out_stall_i kind_o, payload_byte_o, payload_index_o,
//                                              frame_address_o, function_code_o,
//                                              payload_length_o
// cfg       sink       cfg_we_i               cfg_index_i, cfg_wdata_i
//
// One item per cycle while the output is not stalled: input register, parser step, result register.
// An accepted item waits in the input register, then its result is written to the result register.
// Reset returns the parser to header hunt and loads register defaults.
// A stalled result holds the pipe; items causing no result still wait behind it.
module sum_checked_frame_deframer
  import scfd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           kind_o,
  output logic [7:0]           payload_byte_o,
  output logic [7:0]           payload_index_o,
  output logic [7:0]           frame_address_o,
  output logic [7:0]           function_code_o,
  output logic [7:0]           payload_length_o
);

  cfg_t       cfg;
  logic       in_valid_q;
  logic       func_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  result_t    res_q;
  logic       res_valid;
  result_t    res;
  logic       blocked;
  logic       advance;

  assign blocked    = out_valid_q & out_stall_i;
  assign advance    = in_valid_q & ~blocked;
  assign in_stall_o = in_valid_q & blocked;

  scfd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  scfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .func_i      (func_q),
    .rx_byte_i   (byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (!blocked) begin
        out_valid_q <= advance & res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      func_q <= func_i;
      byte_q <= rx_byte_i;
    end
    if (advance && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = res_q.kind;
  assign payload_byte_o   = res_q.payload_byte;
  assign payload_index_o  = res_q.payload_index;
  assign frame_address_o  = res_q.frame_address;
  assign function_code_o  = res_q.function_code;
  assign payload_length_o = res_q.payload_length;

endmodule

// ----- hdl/scfd_cfg.sv -----
module scfd_cfg
  import scfd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TIMEOUT_TICKS: cfg_d.timeout_ticks = cfg_wdata_i[TICK_W-1:0];
        CFG_HEADER_VALUE:  cfg_d.header_value  = cfg_wdata_i[7:0];
        CFG_TAIL_VALUE:    cfg_d.tail_value    = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= TIMEOUT_RESET;
      cfg_q.header_value  <= HEADER_RESET;
      cfg_q.tail_value    <= TAIL_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/scfd_parser.sv -----
module scfd_parser
  import scfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       func_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [FLEN_W-1:0]   pos_q, pos_d;
  logic [7:0]          len_low_q, len_low_d;
  logic [FLEN_W-1:0]   flen_q, flen_d;
  logic [7:0]          addr_q, addr_d;
  logic [7:0]          code_q, code_d;
  logic [7:0]          sum_q, sum_d;
  logic [7:0]          rsum_q, rsum_d;
  logic [TICK_W-1:0]   idle_q, idle_d;

  logic [TOTAL_W-1:0]  total;
  logic [FLEN_W:0]     pos_plus2;
  logic [FLEN_W-1:0]   idx_full;
  logic [FLEN_W-1:0]   plen_full;

  assign total     = {rx_byte_i, len_low_q};
  assign pos_plus2 = {1'b0, pos_q} + (FLEN_W+1)'(2);
  assign idx_full  = pos_q - FLEN_W'(5);
  assign plen_full = flen_q - FLEN_W'(FIXED_BYTES);

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    len_low_d = len_low_q;
    flen_d    = flen_q;
    addr_d    = addr_q;
    code_d    = code_q;
    sum_d     = sum_q;
    rsum_d    = rsum_q;
    idle_d    = idle_q;

    res_valid_o          = 1'b0;
    res_o.kind           = KIND_PAYLOAD;
    res_o.payload_byte   = '0;
    res_o.payload_index  = '0;
    res_o.frame_address  = addr_q;
    res_o.function_code  = code_q;
    res_o.payload_length = (phase_q == PH_BODY) ? plen_full[7:0] : 8'd0;

    if (step_i) begin
      if (func_i) begin
        // tick: only counts inside a frame
        if (phase_q != PH_HUNT) begin
          if (idle_q != '1) begin
            idle_d = idle_q + TICK_W'(1);
          end
          if (idle_d >= cfg_i.timeout_ticks) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_TIMEOUT;
            phase_d     = PH_HUNT;
          end
        end
      end else begin
        unique case (phase_q)
          PH_LEN: begin
            if (pos_q == FLEN_W'(1)) begin
              len_low_d = rx_byte_i;
              pos_d     = FLEN_W'(2);
            end else if (total < TOTAL_W'(FIXED_BYTES) ||
                         total > TOTAL_W'(MAX_FRAME_BYTES)) begin
              res_valid_o = 1'b1;
              res_o.kind  = KIND_BAD_LEN;
              phase_d     = PH_HUNT;
            end else begin
              flen_d  = total[FLEN_W-1:0];
              pos_d   = FLEN_W'(3);
              phase_d = PH_BODY;
            end
          end
          PH_BODY: begin
            pos_d = pos_q + FLEN_W'(1);
            if (pos_q == FLEN_W'(3)) begin
              addr_d = rx_byte_i;
              sum_d  = sum_q + rx_byte_i;
            end else if (pos_q == FLEN_W'(4)) begin
              code_d = rx_byte_i;
              sum_d  = sum_q + rx_byte_i;
            end else if (pos_plus2 < {1'b0, flen_q}) begin
              sum_d               = sum_q + rx_byte_i;
              res_valid_o         = 1'b1;
              res_o.kind          = KIND_PAYLOAD;
              res_o.payload_byte  = rx_byte_i;
              res_o.payload_index = idx_full[7:0];
            end else if (pos_plus2 == {1'b0, flen_q}) begin
              rsum_d = rx_byte_i;
            end else begin
              // tail byte; a bad tail outranks a checksum mismatch
              res_valid_o = 1'b1;
              phase_d     = PH_HUNT;
              if (rx_byte_i != cfg_i.tail_value) begin
                res_o.kind = KIND_BAD_TAIL;
              end else if (sum_q != rsum_q) begin
                res_o.kind = KIND_BAD_SUM;
              end else begin
                res_o.kind = KIND_GOOD;
              end
            end
          end
          default: begin
            if (rx_byte_i == cfg_i.header_value) begin
              phase_d = PH_LEN;
              pos_d   = FLEN_W'(1);
              idle_d  = '0;
              sum_d   = '0;
              rsum_d  = '0;
              addr_d  = '0;
              code_d  = '0;
              flen_d  = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      pos_q     <= '0;
      len_low_q <= '0;
      flen_q    <= '0;
      addr_q    <= '0;
      code_q    <= '0;
      sum_q     <= '0;
      rsum_q    <= '0;
      idle_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      len_low_q <= len_low_d;
      flen_q    <= flen_d;
      addr_q    <= addr_d;
      code_q    <= code_d;
      sum_q     <= sum_d;
      rsum_q    <= rsum_d;
      idle_q    <= idle_d;
    end
  end

endmodule
